/* rtl/complex_arithmetic_unit_defines.svh */
// Assertion macros shared by the complex arithmetic unit.
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

// A property checked at every rising clock edge outside reset.
`define CAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define CAU_IMPLY(lbl, ante, cons, msg) \
  `CAU_ASSERT(lbl, (ante) |-> (cons), msg)

// A condition that must hold in the cycle after its trigger.
`define CAU_NEXT(lbl, ante, cons, msg) \
  `CAU_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

/* rtl/cau_pkg.sv */
package cau_pkg;

  localparam int WORD_BITS = 16;
  localparam int FRAC_BITS = 8;
  localparam int KIND_W    = 3;
  localparam int STAT_W    = 2;

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int PW  = 2 * W;
  localparam int SW  = PW + 1;
  localparam int MW  = PW;
  localparam int XW  = MW + 1;
  localparam int QB  = W + 1;
  localparam int RW  = MW + 1;
  localparam int SQW = W + 3;
  localparam int OVS = QB - F;

  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [STAT_W-1:0] stat_t;

  localparam kind_t K_ADD = 3'd0;
  localparam kind_t K_SUB = 3'd1;
  localparam kind_t K_MUL = 3'd2;
  localparam kind_t K_DIV = 3'd3;
  localparam kind_t K_MAG = 3'd4;

  localparam stat_t ST_OK  = 2'd0;
  localparam stat_t ST_SAT = 2'd1;
  localparam stat_t ST_DZ  = 2'd2;
  localparam stat_t ST_RSV = 2'd3;

  typedef struct packed {
    kind_t          kind;
    logic [W-1:0]   as_re;
    logic [W-1:0]   as_im;
    logic           as_sat;
    logic           neg_re;
    logic           neg_im;
    logic [MW-1:0]  n_re;
    logic [MW-1:0]  n_im;
    logic [MW-1:0]  den;
  } cau_mid_t;

  typedef struct packed {
    cau_mid_t       m;
    logic           ovf_re;
    logic           ovf_im;
    logic [QB-1:0]  q_re;
    logic [QB-1:0]  q_im;
    logic [RW-1:0]  r_re;
    logic [RW-1:0]  r_im;
    logic [W-1:0]   root;
    logic [SQW-1:0] rem;
  } cau_pipe_t;

  typedef struct packed {
    logic [W-1:0] w;
    logic         sat;
  } sat_word_t;

  function automatic sat_word_t sat_word(logic neg, logic [XW-1:0] mag);
    logic [XW-1:0] limit;
    logic [XW-1:0] val;
    sat_word_t     res;
    limit = neg ? (XW'(1) << (W - 1)) : ((XW'(1) << (W - 1)) - XW'(1));
    val = mag;
    res.sat = 1'b0;
    if (mag > limit) begin
      val = limit;
      res.sat = 1'b1;
    end
    res.w = neg ? W'(XW'(0) - val) : W'(val);
    return res;
  endfunction

endpackage

/* rtl/cau_front.sv */
module cau_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic                                in_valid,
  input  cau_pkg::kind_t                      kind,
  input  logic signed [cau_pkg::WORD_BITS-1:0] a_re,
  input  logic signed [cau_pkg::WORD_BITS-1:0] a_im,
  input  logic signed [cau_pkg::WORD_BITS-1:0] b_re,
  input  logic signed [cau_pkg::WORD_BITS-1:0] b_im,
  output logic                                mid_valid,
  output cau_pkg::cau_mid_t                   mid
);
  import cau_pkg::*;

  typedef struct packed {
    kind_t                kind;
    logic signed [PW-1:0] p_rr;
    logic signed [PW-1:0] p_ii;
    logic signed [PW-1:0] p_ri;
    logic signed [PW-1:0] p_ir;
    logic signed [PW-1:0] sq1;
    logic signed [PW-1:0] sq2;
    logic [W-1:0]         as_re;
    logic [W-1:0]         as_im;
    logic                 as_sat;
  } prod_t;

  prod_t               s1_r, s1_nxt;
  logic                s1_valid_r;
  cau_mid_t            s2_r, s2_nxt;
  logic                s2_valid_r;
  logic signed [W-1:0] x1, x2;
  logic signed [W:0]   sum_re, sum_im;
  logic                ov_re, ov_im;
  logic signed [SW-1:0] t_re, t_im;
  logic [SW-1:0]       mag_re, mag_im;

  always_comb begin
    x1 = (kind == K_MAG) ? a_re : b_re;
    x2 = (kind == K_MAG) ? a_im : b_im;
    if (kind == K_SUB) begin
      sum_re = {a_re[W-1], a_re} - {b_re[W-1], b_re};
      sum_im = {a_im[W-1], a_im} - {b_im[W-1], b_im};
    end else begin
      sum_re = {a_re[W-1], a_re} + {b_re[W-1], b_re};
      sum_im = {a_im[W-1], a_im} + {b_im[W-1], b_im};
    end
    ov_re = sum_re[W] != sum_re[W-1];
    ov_im = sum_im[W] != sum_im[W-1];
    s1_nxt.kind   = kind;
    s1_nxt.p_rr   = a_re * b_re;
    s1_nxt.p_ii   = a_im * b_im;
    s1_nxt.p_ri   = a_re * b_im;
    s1_nxt.p_ir   = a_im * b_re;
    s1_nxt.sq1    = x1 * x1;
    s1_nxt.sq2    = x2 * x2;
    s1_nxt.as_re  = ov_re ? {sum_re[W], {(W-1){~sum_re[W]}}} : sum_re[W-1:0];
    s1_nxt.as_im  = ov_im ? {sum_im[W], {(W-1){~sum_im[W]}}} : sum_im[W-1:0];
    s1_nxt.as_sat = ov_re || ov_im;
  end

  always_comb begin
    if (s1_r.kind == K_DIV) begin
      t_re = {s1_r.p_rr[PW-1], s1_r.p_rr} + {s1_r.p_ii[PW-1], s1_r.p_ii};
      t_im = {s1_r.p_ir[PW-1], s1_r.p_ir} - {s1_r.p_ri[PW-1], s1_r.p_ri};
    end else begin
      t_re = {s1_r.p_rr[PW-1], s1_r.p_rr} - {s1_r.p_ii[PW-1], s1_r.p_ii};
      t_im = {s1_r.p_ri[PW-1], s1_r.p_ri} + {s1_r.p_ir[PW-1], s1_r.p_ir};
    end
    mag_re = t_re[SW-1] ? SW'(0) - t_re : t_re;
    mag_im = t_im[SW-1] ? SW'(0) - t_im : t_im;
    s2_nxt.kind   = s1_r.kind;
    s2_nxt.as_re  = s1_r.as_re;
    s2_nxt.as_im  = s1_r.as_im;
    s2_nxt.as_sat = s1_r.as_sat;
    s2_nxt.neg_re = t_re[SW-1];
    s2_nxt.neg_im = t_im[SW-1];
    s2_nxt.n_re   = mag_re[MW-1:0];
    s2_nxt.n_im   = mag_im[MW-1:0];
    s2_nxt.den    = MW'($unsigned(s1_r.sq1)) + MW'($unsigned(s1_r.sq2));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
    end
  end

  assign mid_valid = s2_valid_r;
  assign mid       = s2_r;

endmodule

/* rtl/cau_divsqrt.sv */
`include "complex_arithmetic_unit_defines.svh"

module cau_divsqrt (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               mid_valid,
  input  cau_pkg::cau_mid_t  mid,
  output logic               fin_valid,
  output cau_pkg::cau_pipe_t fin
);
  import cau_pkg::*;

  function automatic logic [RW:0] div_step(logic [RW-1:0] r, logic [MW-1:0] d, logic nb);
    logic [RW-1:0] t;
    t = {r[RW-2:0], nb};
    if (t >= RW'(d)) begin
      return {t - RW'(d), 1'b1};
    end
    return {t, 1'b0};
  endfunction

  cau_pipe_t st_r [0:QB];
  logic      v_r  [0:QB];
  cau_pipe_t init_nxt;

  always_comb begin
    init_nxt        = '0;
    init_nxt.m      = mid;
    init_nxt.ovf_re = {{OVS{1'b0}}, mid.n_re} >= {mid.den, {OVS{1'b0}}};
    init_nxt.ovf_im = {{OVS{1'b0}}, mid.n_im} >= {mid.den, {OVS{1'b0}}};
    init_nxt.r_re   = RW'(mid.n_re >> OVS);
    init_nxt.r_im   = RW'(mid.n_im >> OVS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= init_nxt;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_step
    localparam int K  = QB - 1 - j;
    localparam int KF = (K >= F) ? K - F : 0;
    localparam int KS = (K < W) ? K : 0;
    cau_pipe_t      st_nxt;
    logic           nb_re, nb_im;
    logic [RW:0]    dr_re, dr_im;
    logic [SQW-1:0] rt, tt;

    assign nb_re = (K >= F) ? st_r[j].m.n_re[KF] : 1'b0;
    assign nb_im = (K >= F) ? st_r[j].m.n_im[KF] : 1'b0;

    always_comb begin
      st_nxt = st_r[j];
      dr_re  = div_step(st_r[j].r_re, st_r[j].m.den, nb_re);
      dr_im  = div_step(st_r[j].r_im, st_r[j].m.den, nb_im);
      st_nxt.r_re = dr_re[RW:1];
      st_nxt.r_im = dr_im[RW:1];
      st_nxt.q_re = {st_r[j].q_re[QB-2:0], dr_re[0]};
      st_nxt.q_im = {st_r[j].q_im[QB-2:0], dr_im[0]};
      rt = {st_r[j].rem[SQW-3:0], st_r[j].m.den[2*KS+1], st_r[j].m.den[2*KS]};
      tt = {1'b0, st_r[j].root, 2'b01};
      if (K < W) begin
        if (rt >= tt) begin
          st_nxt.rem  = rt - tt;
          st_nxt.root = {st_r[j].root[W-2:0], 1'b1};
        end else begin
          st_nxt.rem  = rt;
          st_nxt.root = {st_r[j].root[W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j+1] <= 1'b0;
      end else if (adv) begin
        v_r[j+1] <= v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[j+1] <= st_nxt;
      end
    end
  end

  assign fin_valid = v_r[QB];
  assign fin       = st_r[QB];

  `CAU_IMPLY(a_rem_re_below_den, v_r[QB] && (st_r[QB].m.kind == K_DIV) && !st_r[QB].ovf_re && (st_r[QB].m.den != '0), st_r[QB].r_re < RW'(st_r[QB].m.den), "real remainder not below divisor")
  `CAU_IMPLY(a_rem_im_below_den, v_r[QB] && (st_r[QB].m.kind == K_DIV) && !st_r[QB].ovf_im && (st_r[QB].m.den != '0), st_r[QB].r_im < RW'(st_r[QB].m.den), "imaginary remainder not below divisor")

endmodule

/* rtl/cau_back.sv */
`include "complex_arithmetic_unit_defines.svh"

module cau_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic                                fin_valid,
  input  cau_pkg::cau_pipe_t                  fin,
  output logic                                out_valid,
  output logic signed [cau_pkg::WORD_BITS-1:0] res_re,
  output logic signed [cau_pkg::WORD_BITS-1:0] res_im,
  output cau_pkg::stat_t                      status
);
  import cau_pkg::*;

  function automatic logic [XW-1:0] rnd_shift(logic [MW-1:0] n);
    logic [MW:0] t;
    t = {n, 1'b0} >> F;
    return XW'(n >> F) + XW'(t[0]);
  endfunction

  logic          out_valid_r;
  logic [W-1:0]  out_res_re_r, out_res_im_r, re_nxt, im_nxt;
  stat_t         out_status_r, st_nxt;
  sat_word_t     w_re, w_im;
  logic [XW-1:0] q_re, q_im, mag;
  logic          sat;

  always_comb begin
    q_re = fin.ovf_re ? '1 : XW'(fin.q_re) +
           XW'({fin.r_re, 1'b0} >= (RW+1)'(fin.m.den));
    q_im = fin.ovf_im ? '1 : XW'(fin.q_im) +
           XW'({fin.r_im, 1'b0} >= (RW+1)'(fin.m.den));
    mag  = XW'(fin.root) + XW'(fin.rem > SQW'(fin.root));
    w_re = '0;
    w_im = '0;
    re_nxt = '0;
    im_nxt = '0;
    sat = 1'b0;
    st_nxt = ST_OK;
    case (fin.m.kind) inside
      K_ADD, K_SUB: begin
        re_nxt = fin.m.as_re;
        im_nxt = fin.m.as_im;
        sat = fin.m.as_sat;
      end
      K_MUL: begin
        w_re = sat_word(fin.m.neg_re, rnd_shift(fin.m.n_re));
        w_im = sat_word(fin.m.neg_im, rnd_shift(fin.m.n_im));
        re_nxt = w_re.w;
        im_nxt = w_im.w;
        sat = w_re.sat || w_im.sat;
      end
      K_DIV: begin
        if (fin.m.den != '0) begin
          w_re = sat_word(fin.m.neg_re, q_re);
          w_im = sat_word(fin.m.neg_im, q_im);
          re_nxt = w_re.w;
          im_nxt = w_im.w;
          sat = w_re.sat || w_im.sat;
        end
      end
      K_MAG: begin
        w_re = sat_word(1'b0, mag);
        re_nxt = w_re.w;
        sat = w_re.sat;
      end
      default: begin
        re_nxt = '0;
      end
    endcase
    if ((fin.m.kind == K_DIV) && (fin.m.den == '0)) begin
      st_nxt = ST_DZ;
    end else if (sat) begin
      st_nxt = ST_SAT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_re_r <= re_nxt;
      out_res_im_r <= im_nxt;
      out_status_r <= st_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign res_re    = out_res_re_r;
  assign res_im    = out_res_im_r;
  assign status    = out_status_r;

  `CAU_IMPLY(a_dz_zero, out_valid_r && (out_status_r == ST_DZ),
             (out_res_re_r == '0) && (out_res_im_r == '0),
             "divide by zero beat carries a nonzero result")
  `CAU_IMPLY(a_no_rsv, out_valid_r, out_status_r != ST_RSV,
             "reserved status code on a result beat")
  `CAU_NEXT(a_mag_im_zero, adv && fin_valid && (fin.m.kind == K_MAG),
            (out_res_im_r == '0) && (out_status_r != ST_DZ),
            "magnitude beat with nonzero imaginary part")

endmodule

/* rtl/complex_arithmetic_unit.sv */
// Each beat passes the front-end registers, the divide stages and the output register.
// One beat per cycle unless stalled; 17 restoring div and sqrt stages set the depth.
// A stalled output freezes the whole pipeline; it moves again once the result is taken.
// Reset is synchronous and active low; it clears all valid bits, not the data.
module complex_arithmetic_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  cau_pkg::kind_t                      in_kind,
  input  logic signed [cau_pkg::WORD_BITS-1:0] in_a_re,
  input  logic signed [cau_pkg::WORD_BITS-1:0] in_a_im,
  input  logic signed [cau_pkg::WORD_BITS-1:0] in_b_re,
  input  logic signed [cau_pkg::WORD_BITS-1:0] in_b_im,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [cau_pkg::WORD_BITS-1:0] out_res_re,
  output logic signed [cau_pkg::WORD_BITS-1:0] out_res_im,
  output cau_pkg::stat_t                      out_status
);
  import cau_pkg::*;

  logic      adv;
  logic      mid_valid, fin_valid;
  cau_mid_t  mid;
  cau_pipe_t fin;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  cau_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .kind      (in_kind),
    .a_re      (in_a_re),
    .a_im      (in_a_im),
    .b_re      (in_b_re),
    .b_im      (in_b_im),
    .mid_valid (mid_valid),
    .mid       (mid)
  );

  cau_divsqrt u_divsqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .mid_valid (mid_valid),
    .mid       (mid),
    .fin_valid (fin_valid),
    .fin       (fin)
  );

  cau_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .fin_valid (fin_valid),
    .fin       (fin),
    .out_valid (out_valid),
    .res_re    (out_res_re),
    .res_im    (out_res_im),
    .status    (out_status)
  );

endmodule

/* verif/complex_arithmetic_unit_tb.sv */
module complex_arithmetic_unit_tb;
  import cau_pkg::*;

  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef struct packed {
    word_t re;
    word_t im;
    stat_t status;
  } cplx_res_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  kind_t in_kind;
  word_t in_a_re;
  word_t in_a_im;
  word_t in_b_re;
  word_t in_b_im;
  logic out_valid;
  logic out_stall;
  word_t out_res_re;
  word_t out_res_im;
  stat_t out_status;

  cplx_res_t pending_results[$];
  int mismatches;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;
  int hold_left;

  complex_arithmetic_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_a_re(in_a_re), .in_a_im(in_a_im), .in_b_re(in_b_re), .in_b_im(in_b_im),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_res_re(out_res_re), .out_res_im(out_res_im), .out_status(out_status)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic longint unsigned clamp_word(bit neg, longint unsigned mag,
                                                 ref bit sat);
    longint unsigned limit;
    limit = neg ? 64'd32768 : 64'd32767;
    if (mag > limit) begin
      mag = limit;
      sat = 1'b1;
    end
    return neg ? (64'd0 - mag) : mag;
  endfunction

  function automatic longint unsigned round_frac(longint unsigned mag);
    return (mag >> FRAC_BITS) + ((mag >> (FRAC_BITS - 1)) & 64'd1);
  endfunction

  function automatic longint unsigned scaled_quotient(longint unsigned n,
                                                      longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = n / d;
    r = n % d;
    if (q > (64'd1 << (WORD_BITS - FRAC_BITS))) return 64'd1 << WORD_BITS;
    for (int i = 0; i < FRAC_BITS; i++) begin
      q = q << 1;
      if (r >= d - r) begin
        r = r - (d - r);
        q = q | 64'd1;
      end else begin
        r = r << 1;
      end
    end
    if (r >= d - r) q = q + 64'd1;
    return q;
  endfunction

  function automatic longint unsigned rounded_root(longint unsigned s);
    longint unsigned r;
    longint unsigned bitv;
    longint unsigned rem;
    r = 0;
    bitv = 64'd1 << 62;
    rem = s;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= r + bitv) begin
        rem = rem - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    if (rem > r) r = r + 64'd1;
    return r;
  endfunction

  function automatic cplx_res_t compute_complex(kind_t kind, word_t a_re, word_t a_im,
                                                word_t b_re, word_t b_im);
    cplx_res_t res;
    longint ar, ai, br, bi, sr, si;
    longint unsigned d;
    bit sat;
    ar = a_re;
    ai = a_im;
    br = b_re;
    bi = b_im;
    sat = 1'b0;
    res.re = '0;
    res.im = '0;
    res.status = ST_OK;
    case (kind)
      K_ADD, K_SUB: begin
        sr = (kind == K_ADD) ? ar + br : ar - br;
        si = (kind == K_ADD) ? ai + bi : ai - bi;
        res.re = word_t'(clamp_word(sr < 0, sr < 0 ? -sr : sr, sat));
        res.im = word_t'(clamp_word(si < 0, si < 0 ? -si : si, sat));
      end
      K_MUL: begin
        sr = ar * br - ai * bi;
        si = ar * bi + ai * br;
        res.re = word_t'(clamp_word(sr < 0, round_frac(sr < 0 ? -sr : sr), sat));
        res.im = word_t'(clamp_word(si < 0, round_frac(si < 0 ? -si : si), sat));
      end
      K_DIV: begin
        d = br * br + bi * bi;
        if (d == 0) begin
          res.status = ST_DZ;
        end else begin
          sr = ar * br + ai * bi;
          si = ai * br - ar * bi;
          res.re = word_t'(clamp_word(sr < 0, scaled_quotient(sr < 0 ? -sr : sr, d), sat));
          res.im = word_t'(clamp_word(si < 0, scaled_quotient(si < 0 ? -si : si, d), sat));
        end
      end
      K_MAG: begin
        res.re = word_t'(clamp_word(1'b0, rounded_root(ar * ar + ai * ai), sat));
      end
      default: ;
    endcase
    if (sat && res.status == ST_OK) res.status = ST_SAT;
    return res;
  endfunction

  task automatic send_item(kind_t kind, word_t a_re, word_t a_im, word_t b_re, word_t b_im);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_a_re <= a_re;
    in_a_im <= a_im;
    in_b_re <= b_re;
    in_b_im <= b_im;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(compute_complex(kind, a_re, a_im, b_re, b_im));
    @(negedge clk);
  endtask

  function automatic word_t pick_word();
    case ($urandom_range(5))
      0: return word_t'(16'sh8000);
      1: return word_t'(16'sh7fff);
      2: return word_t'($urandom_range(2047)) - word_t'(1024);
      3: return word_t'($urandom_range(7)) - word_t'(3);
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic kind_t pick_kind();
    if ($urandom_range(15) == 0) return kind_t'($urandom_range(7, 5));
    return kind_t'($urandom_range(4));
  endfunction

  task automatic send_random_item();
    kind_t kind;
    word_t b_re, b_im;
    kind = pick_kind();
    b_re = pick_word();
    b_im = pick_word();
    if (kind == K_DIV && $urandom_range(9) == 0) begin
      b_re = '0;
      b_im = '0;
    end
    send_item(kind, pick_word(), ($urandom_range(7) == 0) ? word_t'(0) : pick_word(),
              b_re, b_im);
  endtask

  task automatic test_directed();
    send_item(K_ADD, 16'sh0100, 16'sh0200, 16'sh0080, -16'sh0100);
    send_item(K_ADD, 16'sh7fff, 16'sh8000, 16'sh0001, -16'sh0001);
    send_item(K_ADD, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
    send_item(K_SUB, 16'sh8000, 16'sh7fff, 16'sh0001, -16'sh0001);
    send_item(K_SUB, 16'sh0300, 16'sh0000, 16'sh0100, 16'sh0100);
    send_item(K_MUL, 16'sh0100, 16'sh0100, 16'sh0100, -16'sh0100);
    send_item(K_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_item(K_MUL, 16'sh7fff, 16'sh0000, 16'sh7fff, 16'sh0000);
    send_item(K_MUL, 16'sh0001, 16'sh0001, 16'sh0080, 16'sh0080);
    send_item(K_DIV, 16'sh0100, 16'sh0100, 16'sh0000, 16'sh0000);
    send_item(K_DIV, 16'sh0300, 16'sh0000, 16'sh0100, 16'sh0100);
    send_item(K_DIV, 16'sh0200, 16'sh0100, 16'sh0100, -16'sh0200);
    send_item(K_DIV, 16'sh7fff, 16'sh7fff, 16'sh0001, 16'sh0000);
    send_item(K_DIV, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_item(K_DIV, 16'sh0001, 16'sh0000, 16'sh7fff, 16'sh7fff);
    send_item(K_MAG, 16'sh0300, 16'sh0400, 16'sh1234, 16'sh5678);
    send_item(K_MAG, 16'sh8000, 16'sh8000, 16'sh0000, 16'sh0000);
    send_item(K_MAG, 16'sh0000, 16'sh0000, 16'sh7fff, 16'sh8000);
    send_item(K_MAG, 16'sh0001, -16'sh0001, 16'sh0000, 16'sh0000);
    send_item(kind_t'(5), 16'sh1111, 16'sh2222, 16'sh3333, 16'sh4444);
    send_item(kind_t'(6), 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
    send_item(kind_t'(7), -16'sh0001, -16'sh0001, -16'sh0001, -16'sh0001);
  endtask

  task automatic test_random(int count);
    repeat (count) send_random_item();
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (60) send_random_item();
  endtask

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 300;
    end
    if (hold_left > 0) hold_left = hold_left - 1;
    out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    cplx_res_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat re=%0d im=%0d status=%0d",
                                       out_res_re, out_res_im, out_status);
      end else begin
        exp_res = pending_results.pop_front();
        if (out_res_re !== exp_res.re || out_res_im !== exp_res.im ||
            out_status !== exp_res.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected re=%0d im=%0d status=%0d, got re=%0d im=%0d status=%0d",
                     exp_res.re, exp_res.im, exp_res.status,
                     out_res_re, out_res_im, out_status);
        end
      end
    end
  end

  initial begin
    #(12 * 2000000);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int waited;
    mismatches = 0;
    hold_req = 1'b0;
    hold_left = 0;
    send_idle_pct = 36;
    recv_idle_pct = 55;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = K_ADD;
    in_a_re = '0;
    in_a_im = '0;
    in_b_re = '0;
    in_b_im = '0;
    out_stall = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random(330);
    send_idle_pct = 55;
    recv_idle_pct = 36;
    test_random(330);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random(310);
    in_valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

/* complex_arithmetic_unit.f */
+incdir+rtl
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_divsqrt.sv
rtl/cau_back.sv
rtl/complex_arithmetic_unit.sv
verif/complex_arithmetic_unit_tb.sv
